[rtl/ptsc_pkg.sv]
// Package for the proximity toggle switch controller.
// Holds phase codes, register indexes, reset values, conversion constants
// and the control struct shared by the top level and the echo timer.
package ptsc_pkg;

    // Default counter width (phase counter and echo pulse length)
    localparam int COUNTER_BITS_DEFAULT = 24;

    // Payload widths
    localparam int POT_W    = 10;
    localparam int DIST_W   = 16;
    localparam int CFG_W    = 24;
    localparam int TRIG_W   = 8;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 3'd3;

    // Register reset values
    localparam logic [CFG_W-1:0]  IDLE_DELAY_RST   = 24'd50000;
    localparam logic [CFG_W-1:0]  LOCKOUT_RST      = 24'd700000;
    localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST   = 8'd10;
    localparam logic [CFG_W-1:0]  ECHO_TIMEOUT_RST = 24'd60000;

    // Echo time to centimetres: cm = ticks * 17 / 1000, built up one tick at a time
    localparam int DIST_REM_W = 10;
    localparam logic [DIST_REM_W:0] DIST_STEP = 11'd17;
    localparam logic [DIST_REM_W:0] DIST_DIV  = 11'd1000;
    localparam logic [DIST_W-1:0]   DIST_MAX  = 16'hFFFF;

    // Threshold: pot * 58 / 1024 + 2
    localparam logic [5:0] THR_MULT   = 6'd58;
    localparam int         THR_SHIFT  = 10;
    localparam logic [5:0] THR_OFFSET = 6'd2;

    // Controller phases, one-hot
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_TRIG    = 4'b0010,
        PH_MEASURE = 4'b0100,
        PH_LOCKOUT = 4'b1000
    } phase_t;

    // Echo timer controls, already qualified with item acceptance
    typedef struct packed {
        logic start;   // rising echo edge: pulse length 1
        logic step;    // echo still high: one more tick
    } echo_ctl_t;

endpackage

[rtl/ptsc_echo_timer.sv]
// Echo pulse timer for the proximity toggle switch controller.
// Counts echo high ticks and keeps the matching distance in centimetres
// incrementally (17/1000 cm per tick). Depends on ptsc_pkg.
module ptsc_echo_timer #(
    parameter int COUNTER_BITS = ptsc_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ptsc_pkg::echo_ctl_t             ctl,
    output logic [ptsc_pkg::DIST_W-1:0]     dist_cm
);

    localparam logic [32:0] CNT_MAX_W = (33'd1 << COUNTER_BITS) - 33'd1;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = CNT_MAX_W[COUNTER_BITS-1:0];

    logic [COUNTER_BITS-1:0]           pulse_reg, pulse_next;
    logic [ptsc_pkg::DIST_REM_W-1:0]   rem_reg, rem_next;
    logic [ptsc_pkg::DIST_W-1:0]       cm_reg, cm_next;
    logic [ptsc_pkg::DIST_REM_W:0]     rem_sum;

    assign rem_sum = {1'b0, rem_reg} + ptsc_pkg::DIST_STEP;

    // Pulse length and centimetre accumulator
    always_comb
    begin
        pulse_next = pulse_reg;
        rem_next   = rem_reg;
        cm_next    = cm_reg;
        if (ctl.start)
        begin
            pulse_next = {{(COUNTER_BITS-1){1'b0}}, 1'b1};
            rem_next   = ptsc_pkg::DIST_STEP[ptsc_pkg::DIST_REM_W-1:0];
            cm_next    = '0;
        end
        else if (ctl.step && (pulse_reg != CNT_MAX))
        begin
            pulse_next = pulse_reg + 1'b1;
            if (rem_sum >= ptsc_pkg::DIST_DIV)
            begin
                rem_next = 10'(rem_sum - ptsc_pkg::DIST_DIV);
                if (cm_reg != ptsc_pkg::DIST_MAX)
                begin
                    cm_next = cm_reg + 1'b1;
                end
            end
            else
            begin
                rem_next = rem_sum[ptsc_pkg::DIST_REM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= '0;
            rem_reg   <= '0;
            cm_reg    <= '0;
        end
        else
        begin
            pulse_reg <= pulse_next;
            rem_reg   <= rem_next;
            cm_reg    <= cm_next;
        end
    end

    assign dist_cm = cm_reg;

endmodule

[rtl/proximity_toggle_switch_controller.sv]
// Proximity toggle switch controller: ultrasonic echo ranging, relay toggle.
// Latency: the result of an item is presented the cycle after it is accepted.
// Throughput: one item per cycle while results are taken; the phase counter
// and echo timer update in a single pass; a stalled consumer stalls the input.
// Reset: relay off, idle phase, counters cleared, registers at defaults.
// Depends on ptsc_pkg and ptsc_echo_timer.
module proximity_toggle_switch_controller #(
    parameter int COUNTER_BITS = ptsc_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] echo_level, [1] button_level, [11:2] pot_value, [15:12] zero
    input  logic [ptsc_pkg::IN_W-1:0]           s_axis_tdata,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] trigger_out, [1] relay_on, [2] measure_done, [18:3] distance_cm,
    // [19] detected, [23:20] zero
    output logic [ptsc_pkg::OUT_W-1:0]          m_axis_tdata,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptsc_pkg::CFG_W-1:0]          cfg_data
);

    localparam logic [32:0] CNT_MAX_W = (33'd1 << COUNTER_BITS) - 33'd1;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = CNT_MAX_W[COUNTER_BITS-1:0];
    localparam logic [COUNTER_BITS-1:0] CNT_ONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

    // Clamp a 24-bit register value to the counter range
    function automatic logic [COUNTER_BITS-1:0] clamp_cnt(input logic [23:0] v);
        if ({9'd0, v} > CNT_MAX_W)
            return CNT_MAX;
        else
            return COUNTER_BITS'(v);
    endfunction

    // Same, with a zero value acting as one tick
    function automatic logic [COUNTER_BITS-1:0] limit_cnt(input logic [23:0] v);
        if (v == 24'd0)
            return CNT_ONE;
        else
            return clamp_cnt(v);
    endfunction

    // Configuration registers
    logic [ptsc_pkg::CFG_W-1:0]  idle_delay_reg;
    logic [ptsc_pkg::CFG_W-1:0]  lockout_reg;
    logic [ptsc_pkg::TRIG_W-1:0] trig_width_reg;
    logic [ptsc_pkg::CFG_W-1:0]  echo_timeout_reg;

    // Controller state
    ptsc_pkg::phase_t            phase_reg, phase_next;
    logic [COUNTER_BITS-1:0]     cnt_reg, cnt_next, cnt_inc;
    logic                        started_reg, started_next;
    logic                        prev_echo_reg;
    logic                        relay_reg, relay_next;
    logic [ptsc_pkg::DIST_W-1:0] dist_reg, dist_next;

    // Output register
    logic                        out_valid_reg;
    logic [ptsc_pkg::OUT_W-1:0]  out_data_reg;

    // Per-item signals
    logic                        accept;
    logic                        echo, button;
    logic [ptsc_pkg::POT_W-1:0]  pot;
    logic [15:0]                 thr_prod;
    logic [5:0]                  thres;
    logic                        trig, done, det;
    logic [COUNTER_BITS-1:0]     lim_idle, lim_trig, lim_timeout, lim_lockout;
    logic [ptsc_pkg::DIST_W-1:0] timer_cm;
    ptsc_pkg::echo_ctl_t         ctl, timer_ctl;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign echo   = s_axis_tdata[0];
    assign button = s_axis_tdata[1];
    assign pot    = s_axis_tdata[11:2];

    // Distance threshold from the potentiometer
    assign thr_prod = {6'd0, pot} * {10'd0, ptsc_pkg::THR_MULT};
    assign thres    = thr_prod[ptsc_pkg::THR_SHIFT +: 6] + ptsc_pkg::THR_OFFSET;

    // Phase limits
    assign lim_idle    = clamp_cnt(idle_delay_reg);
    assign lim_trig    = (trig_width_reg == 8'd0) ? CNT_ONE
                       : {{(COUNTER_BITS-8){1'b0}}, trig_width_reg};
    assign lim_timeout = limit_cnt(echo_timeout_reg);
    assign lim_lockout = limit_cnt(lockout_reg);

    assign cnt_inc = (cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_delay_reg   <= ptsc_pkg::IDLE_DELAY_RST;
            lockout_reg      <= ptsc_pkg::LOCKOUT_RST;
            trig_width_reg   <= ptsc_pkg::TRIG_WIDTH_RST;
            echo_timeout_reg <= ptsc_pkg::ECHO_TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ptsc_pkg::CFG_IDLE_DELAY:   idle_delay_reg   <= cfg_data;
                ptsc_pkg::CFG_LOCKOUT:      lockout_reg      <= cfg_data;
                ptsc_pkg::CFG_TRIG_WIDTH:   trig_width_reg   <= cfg_data[7:0];
                ptsc_pkg::CFG_ECHO_TIMEOUT: echo_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Phase sequencing for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        relay_next   = relay_reg;
        dist_next    = dist_reg;
        trig         = 1'b0;
        done         = 1'b0;
        det          = 1'b0;
        ctl          = '0;
        case (phase_reg)
            ptsc_pkg::PH_TRIG:
            begin
                trig = 1'b1;
                if (cnt_inc >= lim_trig)
                begin
                    phase_next   = ptsc_pkg::PH_MEASURE;
                    cnt_next     = '0;
                    started_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            ptsc_pkg::PH_MEASURE:
            begin
                if (started_reg && !echo)
                begin
                    // falling edge: measurement complete
                    dist_next    = timer_cm;
                    done         = 1'b1;
                    started_next = 1'b0;
                    cnt_next     = '0;
                    if (timer_cm < {10'd0, thres})
                    begin
                        relay_next = !relay_reg;
                        det        = 1'b1;
                        phase_next = ptsc_pkg::PH_LOCKOUT;
                    end
                    else
                    begin
                        phase_next = ptsc_pkg::PH_IDLE;
                    end
                end
                else
                begin
                    if (!started_reg)
                    begin
                        if (echo && !prev_echo_reg)
                        begin
                            started_next = 1'b1;
                            ctl.start    = 1'b1;
                        end
                    end
                    else
                    begin
                        ctl.step = 1'b1;
                    end
                    // echo timeout
                    if (cnt_inc >= lim_timeout)
                    begin
                        phase_next   = ptsc_pkg::PH_IDLE;
                        cnt_next     = '0;
                        started_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            ptsc_pkg::PH_LOCKOUT:
            begin
                if (cnt_inc >= lim_lockout)
                begin
                    phase_next = ptsc_pkg::PH_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                // idle wait, also any unknown code
                phase_next = ptsc_pkg::PH_IDLE;
                if (cnt_reg >= lim_idle)
                begin
                    cnt_next = '0;
                    if (!button)
                    begin
                        relay_next = !relay_reg;
                        det        = 1'b1;
                        phase_next = ptsc_pkg::PH_LOCKOUT;
                    end
                    else
                    begin
                        phase_next = ptsc_pkg::PH_TRIG;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
        endcase
    end

    // Timer moves only on accepted items
    assign timer_ctl.start = ctl.start && accept;
    assign timer_ctl.step  = ctl.step && accept;

    ptsc_echo_timer #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_echo_timer (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (timer_ctl),
        .dist_cm (timer_cm)
    );

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ptsc_pkg::PH_IDLE;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            prev_echo_reg <= 1'b0;
            relay_reg     <= 1'b0;
            dist_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
            prev_echo_reg <= echo;
            relay_reg     <= relay_next;
            dist_reg      <= dist_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {4'd0, det, dist_next, done, relay_next, trig};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
